// ----- rtl/pcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg : shared types and constants of the particle charge decoder
// Holds the result and status codes, the decimal split constants and the
// quark-digit charge helpers used by the decode stages.
// ----------------------------------------------------------------------------
package pcd_pkg;

    // status codes
    localparam logic [1:0] ST_TABLE    = 2'd0;
    localparam logic [1:0] ST_COMPOSED = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    // composition kinds
    localparam logic [2:0] KIND_TABLE   = 3'd0;
    localparam logic [2:0] KIND_SPECIAL = 3'd1;
    localparam logic [2:0] KIND_MESON   = 3'd2;
    localparam logic [2:0] KIND_DIQUARK = 3'd3;
    localparam logic [2:0] KIND_PENTA   = 3'd4;
    localparam logic [2:0] KIND_BARYON  = 3'd5;

    // explicit table codes
    localparam logic [31:0] ID_EXC_D    = 32'd4000001;
    localparam logic [31:0] ID_EXC_U    = 32'd4000002;
    localparam logic [31:0] ID_EXC_E    = 32'd4000011;
    localparam logic [31:0] ID_EXC_NUE  = 32'd4000012;
    localparam logic [31:0] ID_SPEC_990 = 32'd990;
    localparam logic [31:0] ID_SPEC_999 = 32'd9990;
    localparam logic [31:0] ID_GEN_LO   = 32'd81;
    localparam logic [31:0] ID_GEN_HI   = 32'd100;

    // split of the magnitude at the millions digit: floor(x / 10^7) by
    // reciprocal multiply, exact for any 32-bit x
    localparam logic [31:0] DEC7       = 32'd10000000;
    localparam int          Q7_SHIFT   = 56;
    localparam int          Q7_W       = 8;
    localparam logic [32:0] Q7_RECIP   =
        33'(((64'd1 << 56) + 64'd9999999) / 64'd10000000);

    // low part below 10^7: floor(x / 10^k), k = 1..6, exact for 24-bit x
    localparam int REM_W   = 24;
    localparam int QUOT_W  = 20;
    localparam int N_QUOT  = 6;
    localparam int REM_SHIFT [N_QUOT] = '{28, 31, 34, 38, 41, 44};
    localparam logic [24:0] REM_RECIP [N_QUOT] = '{
        25'(((64'd1 << 28) + 64'd9) / 64'd10),
        25'(((64'd1 << 31) + 64'd99) / 64'd100),
        25'(((64'd1 << 34) + 64'd999) / 64'd1000),
        25'(((64'd1 << 38) + 64'd9999) / 64'd10000),
        25'(((64'd1 << 41) + 64'd99999) / 64'd100000),
        25'(((64'd1 << 44) + 64'd999999) / 64'd1000000)
    };

    typedef logic [3:0] t_digit;

    // digits of the magnitude from tens up to millions
    typedef struct packed {
        t_digit n;
        t_digit r;
        t_digit l;
        t_digit q1;
        t_digit q2;
        t_digit q3;
    } t_digits;

    // per-request sideband that travels beside the digit split
    typedef struct packed {
        logic              neg;
        logic              zero;
        logic              hit;
        logic signed [2:0] tab;
    } t_side;

    typedef struct packed {
        logic signed [4:0] charge;
        logic [1:0]        status;
        logic [2:0]        kind;
    } t_result;

    // charge of one quark digit in thirds of e (zero digit handled apart)
    function automatic logic signed [4:0] quark_thirds(input t_digit d);
        logic signed [4:0] t;
        if (d == 4'd0 || d == 4'd9) begin
            t = 5'sd0;
        end else if (d[0]) begin
            t = -5'sd1;
        end else begin
            t = 5'sd2;
        end
        return t;
    endfunction

    // round a sum of thirds to a whole e, times 3 (sum lies in -5..10)
    function automatic logic signed [4:0] round_thirds(input logic signed [4:0] s);
        logic signed [4:0] r;
        if (s > 5'sd7) begin
            r = 5'sd9;
        end else if (s > 5'sd4) begin
            r = 5'sd6;
        end else if (s > 5'sd1) begin
            r = 5'sd3;
        end else if (s > -5'sd2) begin
            r = 5'sd0;
        end else if (s > -5'sd5) begin
            r = -5'sd3;
        end else begin
            r = -5'sd6;
        end
        return r;
    endfunction

endpackage

// ----- rtl/particle_id_charge_decode_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_id_charge_decode_core : particle code to electric charge decoder
// Decodes one signed particle numbering code per request into its charge in
// thirds of e, with a status and the composition kind used.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive i_particle_id and raise i_start. A request is
//   taken on every rising edge where i_start is high and o_busy is low;
//   o_busy is held low, so a request may be issued on every cycle.
//   Result channel: o_done pulses high for one cycle with o_charge_thirds,
//   o_status and o_kind valid in that same cycle. Results leave in request
//   order, one per request.
//   Throughput: one request per cycle. The stage chain is the input
//   register, magnitude, split at 10^7, remainder, power-of-ten
//   quotients, and the result register.
//   Reset: i_rst_n low on a rising edge clears every in-flight request;
//   no o_done follows for requests taken before reset.
//   The receiver cannot stall: a result is shown once and then dropped.
// ----------------------------------------------------------------------------
module particle_id_charge_decode_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic signed [31:0] i_particle_id,
    output logic              o_done,
    output logic signed [4:0] o_charge_thirds,
    output logic [1:0]        o_status,
    output logic [2:0]        o_kind
);
    import pcd_pkg::*;

    localparam int N_VLD = 5;

    logic              accept;
    logic [N_VLD-1:0]  r_vld;
    logic [N_VLD-1:0]  n_vld;
    logic              r_done;

    logic [31:0]       r_id;
    logic [31:0]       r_mag;
    logic              r_neg;
    logic              r_zero;

    logic              tab_hit;
    logic signed [2:0] tab_thirds;
    t_side             side1;
    t_side             r_side2;
    t_side             r_side3;
    t_side             r_side4;

    t_digits           digits;
    t_result           res_next;
    t_result           r_res;

    // no internal back-pressure: every request is taken
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // advance the valid chain one stage per cycle
    assign n_vld = {r_vld[N_VLD-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_done <= r_vld[N_VLD-1];
        end
    end

    // input register, then magnitude and sign flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id <= i_particle_id;
        end
        r_mag  <= r_id[31] ? (32'd0 - r_id) : r_id;
        r_neg  <= r_id[31];
        r_zero <= (r_id == 32'd0);
    end

    pcd_table u_table (
        .i_mag    (r_mag),
        .i_neg    (r_neg),
        .o_hit    (tab_hit),
        .o_thirds (tab_thirds)
    );

    assign side1.neg  = r_neg;
    assign side1.zero = r_zero;
    assign side1.hit  = tab_hit;
    assign side1.tab  = tab_thirds;

    // hold the sideband in step with the digit split stages
    always_ff @(posedge i_clk) begin
        r_side2 <= side1;
        r_side3 <= r_side2;
        r_side4 <= r_side3;
    end

    pcd_digit_split u_split (
        .i_clk    (i_clk),
        .i_mag    (r_mag),
        .o_digits (digits)
    );

    pcd_compose u_compose (
        .i_digits (digits),
        .i_side   (r_side4),
        .o_result (res_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        r_res <= res_next;
    end

    assign o_done          = r_done;
    assign o_charge_thirds = r_res.charge;
    assign o_status        = r_res.status;
    assign o_kind          = r_res.kind;

    // every accepted request comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##6 o_done)
        else $error("accepted request produced no result");

    // no result without a matching request
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 6))
        else $error("result without request");

    // error outcomes carry no charge
    a_err_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_ZERO || o_status == ST_MISSING))
        |-> (o_charge_thirds == 5'sd0))
        else $error("charge on error status");

    // table and zero outcomes report the table kind
    a_table_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_TABLE || o_status == ST_ZERO))
        |-> (o_kind == KIND_TABLE))
        else $error("kind set on table or zero outcome");

endmodule

// ----- rtl/pcd_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_table : fixed code table match
// Matches the code magnitude against the explicit table and gives the
// charge in thirds of e for a hit, before any antiparticle sign flip.
// ----------------------------------------------------------------------------
module pcd_table (
    input  logic [31:0]       i_mag,
    input  logic              i_neg,
    output logic              o_hit,
    output logic signed [2:0] o_thirds
);
    import pcd_pkg::*;

    always_comb begin
        o_hit    = 1'b1;
        o_thirds = 3'sd0;
        case (i_mag) inside
            32'd1, 32'd3, 32'd5, 32'd7, ID_EXC_D: begin
                o_thirds = -3'sd1;
            end
            32'd2, 32'd4, 32'd6, 32'd8, ID_EXC_U: begin
                o_thirds = 3'sd2;
            end
            32'd11, 32'd13, 32'd15, 32'd17, ID_EXC_E: begin
                o_thirds = -3'sd3;
            end
            32'd24, 32'd34, 32'd37: begin
                o_thirds = 3'sd3;
            end
            32'd9, 32'd12, 32'd14, 32'd16, 32'd18, ID_EXC_NUE,
            32'd21, 32'd22, 32'd23, 32'd25, 32'd32, 32'd33,
            32'd35, 32'd36, 32'd39, 32'd41, 32'd42,
            32'd110, ID_SPEC_990, ID_SPEC_999: begin
                o_thirds = 3'sd0;
            end
            [ID_GEN_LO:ID_GEN_HI]: begin
                // generator codes count only for particles
                o_hit = !i_neg;
            end
            default: begin
                o_hit = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/pcd_digit_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_digit_split : pipelined decimal digit extraction
// Three register stages: quotient by 10^7, remainder below 10^7, then the
// six quotients by powers of ten. Digits follow from adjacent quotients.
// ----------------------------------------------------------------------------
module pcd_digit_split (
    input  logic            i_clk,
    input  logic [31:0]     i_mag,
    output pcd_pkg::t_digits o_digits
);
    import pcd_pkg::*;

    logic [64:0]        q7_prod;
    logic [31:0]        r_mag;
    logic [Q7_W-1:0]    r_q7;
    logic [31:0]        rem_full;
    logic [REM_W-1:0]   r_rem;
    logic [63:0]        quot_prod [N_QUOT];
    logic [QUOT_W-1:0]  r_quot [N_QUOT];
    t_digit             dig [N_QUOT];

    assign q7_prod  = 65'(i_mag) * 65'(Q7_RECIP);
    assign rem_full = r_mag - 32'(r_q7) * DEC7;

    always_ff @(posedge i_clk) begin
        r_mag <= i_mag;
        r_q7  <= q7_prod[Q7_SHIFT +: Q7_W];
        r_rem <= rem_full[REM_W-1:0];
    end

    for (genvar g = 0; g < N_QUOT; g++) begin : g_quot
        assign quot_prod[g] = 64'(r_rem) * 64'(REM_RECIP[g]);

        always_ff @(posedge i_clk) begin
            r_quot[g] <= quot_prod[g][REM_SHIFT[g] +: QUOT_W];
        end

        // digit = quotient minus ten times the next quotient
        if (g == N_QUOT - 1) begin : g_top
            assign dig[g] = r_quot[g][3:0];
        end else begin : g_mid
            logic [QUOT_W+3:0] diff;
            assign diff = (QUOT_W+4)'(r_quot[g])
                        - (((QUOT_W+4)'(r_quot[g+1]) << 3)
                        +  ((QUOT_W+4)'(r_quot[g+1]) << 1));
            assign dig[g] = diff[3:0];
        end
    end

    assign o_digits.q3 = dig[0];
    assign o_digits.q2 = dig[1];
    assign o_digits.q1 = dig[2];
    assign o_digits.l  = dig[3];
    assign o_digits.r  = dig[4];
    assign o_digits.n  = dig[5];

endmodule

// ----- rtl/pcd_compose.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_compose : charge composition
// Picks the composition from the digit pattern, sums quark charges, rounds
// to whole e and applies the sign, zero-id, missing-quark and table outcomes.
// ----------------------------------------------------------------------------
module pcd_compose (
    input  pcd_pkg::t_digits i_digits,
    input  pcd_pkg::t_side   i_side,
    output pcd_pkg::t_result o_result
);
    import pcd_pkg::*;

    logic signed [4:0] sum;
    logic signed [4:0] rounded;
    logic              miss;
    logic [2:0]        kind;

    always_comb begin
        sum  = 5'sd0;
        miss = 1'b0;
        kind = KIND_TABLE;
        if (i_digits.n == 4'd9 && i_digits.r == 4'd9) begin
            kind = KIND_SPECIAL;
        end else if (i_digits.q1 == 4'd0) begin
            kind = KIND_MESON;
            sum  = quark_thirds(i_digits.q2) - quark_thirds(i_digits.q3);
            miss = (i_digits.q2 == 4'd0) || (i_digits.q3 == 4'd0);
        end else if (i_digits.q3 == 4'd0) begin
            kind = KIND_DIQUARK;
            sum  = quark_thirds(i_digits.q2) + quark_thirds(i_digits.q1);
            miss = (i_digits.q2 == 4'd0);
        end else if (i_digits.n == 4'd9) begin
            kind = KIND_PENTA;
            sum  = quark_thirds(i_digits.r) + quark_thirds(i_digits.l)
                 + quark_thirds(i_digits.q1) + quark_thirds(i_digits.q2)
                 + quark_thirds(i_digits.q3);
            miss = (i_digits.r == 4'd0) || (i_digits.l == 4'd0)
                || (i_digits.q2 == 4'd0);
        end else begin
            kind = KIND_BARYON;
            sum  = quark_thirds(i_digits.q1) + quark_thirds(i_digits.q2)
                 + quark_thirds(i_digits.q3);
            miss = (i_digits.q2 == 4'd0);
        end
    end

    assign rounded = round_thirds(sum);

    always_comb begin
        o_result.charge = 5'sd0;
        o_result.status = ST_COMPOSED;
        o_result.kind   = KIND_TABLE;
        if (i_side.zero) begin
            o_result.status = ST_ZERO;
        end else if (i_side.hit) begin
            o_result.status = ST_TABLE;
            o_result.charge = i_side.neg ? -5'(i_side.tab) : 5'(i_side.tab);
        end else begin
            o_result.kind = kind;
            if (miss) begin
                o_result.status = ST_MISSING;
            end else begin
                o_result.charge = i_side.neg ? -rounded : rounded;
            end
        end
    end

endmodule
